### hw/rtl/aunp_pkg.sv
// Shared types and constants for the ASCII unsigned number parser.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aunp_pkg;

  localparam int unsigned CH_W           = 8;
  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned OFFSET_W       = 16;
  localparam int unsigned BASE_W         = 6;
  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam logic [BASE_W-1:0] DEFAULT_BASE = BASE_W'(10);
  localparam logic [BASE_W-1:0] HEX_BASE     = BASE_W'(16);
  localparam logic [BASE_W-1:0] OCT_BASE     = BASE_W'(8);

  localparam logic [CH_W-1:0] CHAR_NUL  = 8'h00;
  localparam logic [CH_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CH_W-1:0] CHAR_NINE = 8'h39;
  localparam logic [CH_W-1:0] CHAR_LA   = 8'h61;
  localparam logic [CH_W-1:0] CHAR_LZ   = 8'h7A;
  localparam logic [CH_W-1:0] CHAR_UA   = 8'h41;
  localparam logic [CH_W-1:0] CHAR_UZ   = 8'h5A;
  localparam logic [CH_W-1:0] CHAR_X    = 8'h78;
  localparam logic [CH_W-1:0] CHAR_O    = 8'h6F;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            first;
  } in_word_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [OFFSET_W-1:0] end_offset;
  } out_word_t;

  // Parser state apart from the character count
  typedef struct packed {
    logic [VALUE_W-1:0] acc;
    logic [BASE_W-1:0]  base;
    logic               lead_zero;
    logic               finished;
  } parse_state_t;

endpackage

`default_nettype wire

### hw/rtl/aunp_step.sv
// One character step of the parser: next state and optional result word.
// Depends on aunp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aunp_step #(
  parameter int unsigned COUNT_BITS = aunp_pkg::COUNT_BITS_DEF
) (
  input  aunp_pkg::in_word_t                  word_i,
  input  logic [aunp_pkg::BASE_W-1:0]         req_base_i,
  input  aunp_pkg::parse_state_t              state_i,
  input  logic [COUNT_BITS-1:0]               count_i,
  output aunp_pkg::parse_state_t              state_o,
  output logic [COUNT_BITS-1:0]               count_o,
  output logic                                emit_o,
  output aunp_pkg::out_word_t                 result_o
);

  localparam int unsigned WIDE_W =
    (COUNT_BITS > aunp_pkg::OFFSET_W) ? COUNT_BITS : aunp_pkg::OFFSET_W;

  aunp_pkg::parse_state_t        eff;
  logic [COUNT_BITS-1:0]         cnt_eff;
  logic [COUNT_BITS-1:0]         cnt_inc;
  logic [WIDE_W-1:0]             cnt_wide;
  logic [aunp_pkg::CH_W-1:0]     c;
  logic [aunp_pkg::BASE_W-1:0]   digit;
  logic                          is_digit;
  logic [aunp_pkg::VALUE_W-1:0]  acc_next;

  assign c = word_i.ch;

  always_comb begin
    if (word_i.first) begin
      eff.acc       = '0;
      eff.base      = (req_base_i != '0) ? req_base_i : aunp_pkg::DEFAULT_BASE;
      eff.lead_zero = 1'b0;
      eff.finished  = 1'b0;
      cnt_eff       = '0;
    end else begin
      eff     = state_i;
      cnt_eff = count_i;
    end
  end

  assign cnt_inc = (&cnt_eff) ? cnt_eff : cnt_eff + COUNT_BITS'(1);

  always_comb begin
    digit    = '0;
    is_digit = 1'b1;
    if (c >= aunp_pkg::CHAR_ZERO && c <= aunp_pkg::CHAR_NINE) begin
      digit = aunp_pkg::BASE_W'(c - aunp_pkg::CHAR_ZERO);
    end else if (c >= aunp_pkg::CHAR_LA && c <= aunp_pkg::CHAR_LZ) begin
      digit = aunp_pkg::BASE_W'(c - aunp_pkg::CHAR_LA) + aunp_pkg::BASE_W'(10);
    end else if (c >= aunp_pkg::CHAR_UA && c <= aunp_pkg::CHAR_UZ) begin
      digit = aunp_pkg::BASE_W'(c - aunp_pkg::CHAR_UA) + aunp_pkg::BASE_W'(10);
    end else begin
      is_digit = 1'b0;
    end
  end

  assign acc_next = aunp_pkg::VALUE_W'(eff.acc * eff.base)
                  + aunp_pkg::VALUE_W'(digit);

  always_comb begin
    state_o = eff;
    count_o = cnt_eff;
    emit_o  = 1'b0;
    if (!word_i.first && state_i.finished) begin
      state_o = state_i;
      count_o = count_i;
    end else if (c == aunp_pkg::CHAR_NUL) begin
      emit_o = 1'b1;
    end else if (cnt_eff == '0 && c == aunp_pkg::CHAR_ZERO) begin
      state_o.lead_zero = 1'b1;
      count_o           = cnt_inc;
    end else if (eff.lead_zero && cnt_eff == COUNT_BITS'(1) && c == aunp_pkg::CHAR_X) begin
      state_o.base = aunp_pkg::HEX_BASE;
      count_o      = cnt_inc;
    end else if (eff.lead_zero && cnt_eff == COUNT_BITS'(1) && c == aunp_pkg::CHAR_O) begin
      state_o.base = aunp_pkg::OCT_BASE;
      count_o      = cnt_inc;
    end else if (!is_digit || digit >= eff.base) begin
      emit_o = 1'b1;
    end else begin
      state_o.acc = acc_next;
      count_o     = cnt_inc;
    end
    if (emit_o) begin
      state_o.finished = 1'b1;
    end
  end

  assign cnt_wide            = WIDE_W'(cnt_eff);
  assign result_o.value      = eff.acc;
  assign result_o.end_offset = (cnt_wide > WIDE_W'({aunp_pkg::OFFSET_W{1'b1}}))
                             ? {aunp_pkg::OFFSET_W{1'b1}}
                             : cnt_wide[aunp_pkg::OFFSET_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/ascii_unsigned_number_parser.sv
// Top level of the ASCII unsigned number parser: input register, step logic, result register.
// Depends on aunp_pkg and aunp_step.
`timescale 1ns / 1ps
`default_nettype none

// Takes one character word per cycle while no result word waits to be taken, and returns one
// result word (value and stop offset) when a NUL, a non-digit or an out-of-range digit ends
// the string. A word with first set starts a new string and loads the radix from the base
// register (0 means ten); "0x" and "0o" prefixes switch to 16 and 8. Throughput is one
// character per cycle while no result word waits; from input accept to result valid a word
// passes the input register, which feeds the single multiply-add step, and then the result
// register, which takes the step's outcome when the step fires. A result word not yet taken
// holds the step. The base register takes effect at the next first-marked character.
module ascii_unsigned_number_parser #(
  parameter int unsigned COUNT_BITS = aunp_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  aunp_pkg::in_word_t           in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output aunp_pkg::out_word_t          out_word_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [aunp_pkg::BASE_W-1:0]  cfg_data_i
);

  logic [aunp_pkg::BASE_W-1:0] req_base_q;
  logic                        in_valid_q;
  aunp_pkg::in_word_t          in_word_q;
  aunp_pkg::parse_state_t      state_q, state_d;
  logic [COUNT_BITS-1:0]       count_q, count_d;
  logic                        emit;
  aunp_pkg::out_word_t         result;
  logic                        out_valid_q;
  aunp_pkg::out_word_t         out_word_q;
  logic                        step_fire;

  assign cfg_ready_o = 1'b1;
  assign step_fire   = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || step_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_base_q <= '0;
    end else if (cfg_valid_i) begin
      req_base_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_word_q <= in_word_i;
    end
  end

  aunp_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .word_i    (in_word_q),
    .req_base_i(req_base_q),
    .state_i   (state_q),
    .count_i   (count_q),
    .state_o   (state_d),
    .count_o   (count_d),
    .emit_o    (emit),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.acc       <= '0;
      state_q.base      <= aunp_pkg::DEFAULT_BASE;
      state_q.lead_zero <= 1'b0;
      state_q.finished  <= 1'b0;
      count_q           <= '0;
    end else if (step_fire) begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_fire) begin
      out_valid_q <= emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire && emit) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire
